// File: design/pss_pkg.sv
package pss_pkg;

  localparam int NUM_PROCESSES = 64;
  localparam int NUM_LEVELS    = 8;
  localparam int PID_W         = $clog2(NUM_PROCESSES);
  localparam int LVL_W         = $clog2(NUM_LEVELS);
  localparam int CNT_W         = PID_W + 1;
  localparam int BURST_W       = 4;
  localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(5);

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_READY    = 3'd1,
    CMD_PREEMPT  = 3'd2,
    CMD_BLOCK    = 3'd3,
    CMD_SCHEDULE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } proc_st_e;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    proc_st_e         st;
  } pcb_t;

endpackage

// File: design/pss_ram.sv
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/priority_scheduler_anti_starvation.sv
// Channel        | Direction | Contents
// s_axis         | in        | tdata: command, process_id, priority_req
// m_axis         | out       | tdata: status, chosen_valid, chosen_id
// burst_limit    | in        | write enable and 4-bit value
// A result is valid on the edge that accepts an unknown command, on the next edge for
// start, ready, preempt and block, and for schedule after a walk over the levels from
// the top, then a dequeue and a link read if a process is picked; else after the walk.
// The walk over the levels and the registered read of each memory set this timing.
// An item is taken only while idle and the output register is empty.
// Reset marks every process unused and empties every queue at once.
module priority_scheduler_anti_starvation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // command[2:0], process_id[8:3], priority_req[11:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // status[0], chosen_valid[1], chosen_id[7:2]
  input  logic        burst_limit_we_i,
  input  logic [3:0]  burst_limit_i
);

  localparam int NP = pss_pkg::NUM_PROCESSES;
  localparam int NL = pss_pkg::NUM_LEVELS;
  localparam int PW = pss_pkg::PID_W;
  localparam int LW = pss_pkg::LVL_W;
  localparam int CW = pss_pkg::CNT_W;
  localparam int BW = pss_pkg::BURST_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_WALK = 5'b00100,
    S_DEQ  = 5'b01000,
    S_LINK = 5'b10000
  } fsm_e;

  fsm_e                     state_q, state_d;
  logic [BW-1:0]            limit_q;
  logic [2:0]               cmd_q, cmd_d;
  logic [PW-1:0]            pid_q, pid_d;
  logic [2:0]               prio_q, prio_d;
  logic                     used_rd_q, used_rd_d;
  logic [NP-1:0]            used_q, used_d;
  logic [LW-1:0]            lvl_q, lvl_d, fb_q, fb_d, sel_q, sel_d;
  logic                     fbv_q, fbv_d;
  logic [PW-1:0]            pick_q, pick_d;
  logic [CW-1:0]            qc_q [NL];
  logic [CW-1:0]            qc_d [NL];
  logic [BW-1:0]            bc_q [NL];
  logic [BW-1:0]            bc_d [NL];
  logic [PW-1:0]            head_q [NL];
  logic [PW-1:0]            head_d [NL];
  logic [PW-1:0]            tail_q [NL];
  logic [PW-1:0]            tail_d [NL];
  logic                     mv_q, mv_d;
  logic [7:0]               md_q, md_d;

  logic                     pcb_we;
  logic [PW-1:0]            pcb_waddr;
  pss_pkg::pcb_t            pcb_wdata, pcb_rd;
  logic [$bits(pss_pkg::pcb_t)-1:0] pcb_rdata;
  logic                     nl_we;
  logic [PW-1:0]            nl_waddr, nl_wdata, nl_raddr, nl_rdata;

  logic [2:0]               in_cmd;
  logic [PW-1:0]            in_pid;
  logic [2:0]               in_prio;
  pss_pkg::proc_st_e        cur_st;
  logic                     ok, nonempty, take;
  logic [LW-1:0]            fb_n, push_lvl;
  logic                     fbv_n;

  assign in_cmd  = s_axis_tdata[2:0];
  assign in_pid  = s_axis_tdata[3 +: PW];
  assign in_prio = s_axis_tdata[11:9];
  assign pcb_rd  = pss_pkg::pcb_t'(pcb_rdata);
  assign cur_st  = used_rd_q ? pcb_rd.st : pss_pkg::ST_UNUSED;
  assign push_lvl = pcb_rd.level;

  assign s_axis_tready = (state_q == S_IDLE) && !mv_q;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

  pss_ram #(.WIDTH($bits(pss_pkg::pcb_t)), .DEPTH(NP)) u_pcb_ram (
    .clk_i   (clk_i),
    .we_i    (pcb_we),
    .waddr_i (pcb_waddr),
    .wdata_i (pcb_wdata),
    .raddr_i (in_pid),
    .rdata_o (pcb_rdata)
  );

  pss_ram #(.WIDTH(PW), .DEPTH(NP)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .raddr_i (nl_raddr),
    .rdata_o (nl_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pid_d     = pid_q;
    prio_d    = prio_q;
    used_rd_d = used_rd_q;
    used_d    = used_q;
    lvl_d     = lvl_q;
    fb_d      = fb_q;
    fbv_d     = fbv_q;
    sel_d     = sel_q;
    pick_d    = pick_q;
    qc_d      = qc_q;
    bc_d      = bc_q;
    head_d    = head_q;
    tail_d    = tail_q;
    mv_d      = mv_q && !m_axis_tready;
    md_d      = md_q;
    pcb_we    = 1'b0;
    pcb_waddr = pid_q;
    pcb_wdata = pcb_rd;
    nl_we     = 1'b0;
    nl_waddr  = tail_q[push_lvl];
    nl_wdata  = pid_q;
    nl_raddr  = head_q[sel_q];
    ok        = 1'b0;
    nonempty  = qc_q[lvl_q] != '0;
    take      = nonempty && (bc_q[lvl_q] < limit_q);
    fb_n      = nonempty ? lvl_q : fb_q;
    fbv_n     = fbv_q || nonempty;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d     = in_cmd;
          pid_d     = in_pid;
          prio_d    = in_prio;
          used_rd_d = used_q[in_pid];
          case (in_cmd)
            pss_pkg::CMD_SCHEDULE: begin
              state_d = S_WALK;
              lvl_d   = LW'(NL - 1);
              fbv_d   = 1'b0;
            end
            pss_pkg::CMD_START, pss_pkg::CMD_READY,
            pss_pkg::CMD_PREEMPT, pss_pkg::CMD_BLOCK: begin
              state_d = S_LOOK;
            end
            default: begin
              mv_d = 1'b1;
              md_d = 8'h01;
            end
          endcase
        end
      end
      S_LOOK: begin
        case (cmd_q)
          pss_pkg::CMD_START: begin
            ok = (cur_st == pss_pkg::ST_UNUSED) && (32'(prio_q) < NL);
            pcb_wdata.st    = pss_pkg::ST_WAITING;
            pcb_wdata.level = LW'(prio_q);
            if (ok) begin
              used_d[pid_q] = 1'b1;
            end
          end
          pss_pkg::CMD_BLOCK: begin
            ok = cur_st == pss_pkg::ST_RUNNING;
            pcb_wdata.st = pss_pkg::ST_WAITING;
          end
          default: begin
            ok = (cmd_q == pss_pkg::CMD_READY) ? (cur_st == pss_pkg::ST_WAITING)
                                               : (cur_st == pss_pkg::ST_RUNNING);
            pcb_wdata.st = pss_pkg::ST_READY;
            if (ok) begin
              if (qc_q[push_lvl] == '0) begin
                head_d[push_lvl] = pid_q;
              end else begin
                nl_we = 1'b1;
              end
              tail_d[push_lvl] = pid_q;
              qc_d[push_lvl]   = qc_q[push_lvl] + CW'(1);
            end
          end
        endcase
        pcb_we  = ok;
        mv_d    = 1'b1;
        md_d    = {7'd0, !ok};
        state_d = S_IDLE;
      end
      S_WALK: begin
        if (take) begin
          sel_d   = lvl_q;
          state_d = S_DEQ;
        end else begin
          bc_d[lvl_q] = '0;
          if (lvl_q == '0) begin
            if (fbv_n) begin
              sel_d   = fb_n;
              state_d = S_DEQ;
            end else begin
              mv_d    = 1'b1;
              md_d    = 8'h00;
              state_d = S_IDLE;
            end
          end else begin
            lvl_d = lvl_q - LW'(1);
            fb_d  = fb_n;
            fbv_d = fbv_n;
          end
        end
      end
      S_DEQ: begin
        pick_d          = head_q[sel_q];
        qc_d[sel_q]     = qc_q[sel_q] - CW'(1);
        bc_d[sel_q]     = bc_q[sel_q] + BW'(1);
        pcb_we          = 1'b1;
        pcb_waddr       = head_q[sel_q];
        pcb_wdata.st    = pss_pkg::ST_RUNNING;
        pcb_wdata.level = sel_q;
        state_d         = S_LINK;
      end
      S_LINK: begin
        if (qc_q[sel_q] != '0) begin
          head_d[sel_q] = nl_rdata;
        end
        mv_d    = 1'b1;
        md_d    = {pick_q, 1'b1, 1'b0};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= pss_pkg::BURST_RESET;
      used_q  <= '0;
      mv_q    <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        qc_q[i] <= '0;
        bc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (burst_limit_we_i) begin
        limit_q <= burst_limit_i;
      end
      used_q <= used_d;
      mv_q   <= mv_d;
      qc_q   <= qc_d;
      bc_q   <= bc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pid_q     <= pid_d;
    prio_q    <= prio_d;
    used_rd_q <= used_rd_d;
    lvl_q     <= lvl_d;
    fb_q      <= fb_d;
    fbv_q     <= fbv_d;
    sel_q     <= sel_d;
    pick_q    <= pick_d;
    md_q      <= md_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
  end

endmodule
